FILE: sv/ltlc_pkg.sv
// Shared types, constants and helper functions of the line token lexer.
// Used by ltlc_lexer, ltlc_out_skid and line_token_lexer_classifier_top.
package ltlc_pkg;

  localparam int MAX_LINE    = 4096;
  localparam int COL_W       = $clog2(MAX_LINE);
  localparam int START_W     = $clog2(MAX_LINE + 1);
  localparam int IDX_W       = 11;
  localparam int START_OUT_W = 12;
  localparam int LEN_OUT_W   = 13;
  localparam int PROG_W      = 3;

  localparam int IDX_MAX       = 2047;
  localparam int START_OUT_MAX = 4095;
  localparam int LEN_OUT_MAX   = 4096;

  localparam int START_CMP_W = (START_W > START_OUT_W) ? START_W : START_OUT_W;
  localparam int LEN_CMP_W   = (START_W > LEN_OUT_W) ? START_W : LEN_OUT_W;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CASE_STEP  = 8'd32;

  localparam logic [PROG_W-1:0] PROG_DEAD = 3'd7;
  localparam logic [PROG_W-1:0] TRUE_LEN  = 3'd4;
  localparam logic [PROG_W-1:0] FALSE_LEN = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PLAIN,
    MODE_STRING
  } lex_mode_e;

  typedef enum logic [2:0] {
    TT_INTEGER   = 3'd0,
    TT_DECIMAL   = 3'd1,
    TT_STRING    = 3'd2,
    TT_BOOLEAN   = 3'd3,
    TT_REFERENCE = 3'd4,
    TT_SIMPLE    = 3'd5
  } token_type_e;

  typedef struct packed {
    logic              all_digits;
    logic              dot_seen;
    logic              decimal_broken;
    logic              first_upper;
    logic [PROG_W-1:0] true_prog;
    logic [PROG_W-1:0] false_prog;
  } tok_flags_t;

  typedef struct packed {
    token_type_e            token_type;
    logic [IDX_W-1:0]       token_index;
    logic [START_OUT_W-1:0] start_column;
    logic [LEN_OUT_W-1:0]   token_length;
    logic                   last_in_line;
  } token_t;

  localparam tok_flags_t FLAGS_RESET = '{
    all_digits:     1'b1,
    dot_seen:       1'b0,
    decimal_broken: 1'b0,
    first_upper:    1'b0,
    true_prog:      '0,
    false_prog:     '0
  };

  function automatic logic is_upper(logic [7:0] c);
    return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
  endfunction

  function automatic logic [7:0] lower_of(logic [7:0] c);
    return is_upper(c) ? c + CASE_STEP : c;
  endfunction

  function automatic logic [7:0] true_char(logic [PROG_W-1:0] prog);
    logic [7:0] r;
    case (prog)
      3'd0:    r = "t";
      3'd1:    r = "r";
      3'd2:    r = "u";
      3'd3:    r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] false_char(logic [PROG_W-1:0] prog);
    logic [7:0] r;
    case (prog)
      3'd0:    r = "f";
      3'd1:    r = "a";
      3'd2:    r = "l";
      3'd3:    r = "s";
      3'd4:    r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic tok_flags_t add_char(tok_flags_t f, logic [7:0] c);
    tok_flags_t r;
    logic       digit;
    r     = f;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (!digit) begin
      r.all_digits = 1'b0;
      if (c == CH_DOT) begin
        if (f.dot_seen) r.decimal_broken = 1'b1;
        r.dot_seen = 1'b1;
      end else begin
        r.decimal_broken = 1'b1;
      end
    end
    if ((f.true_prog < TRUE_LEN) && (lower_of(c) == true_char(f.true_prog))) begin
      r.true_prog = f.true_prog + 3'd1;
    end else begin
      r.true_prog = PROG_DEAD;
    end
    if ((f.false_prog < FALSE_LEN) && (lower_of(c) == false_char(f.false_prog))) begin
      r.false_prog = f.false_prog + 3'd1;
    end else begin
      r.false_prog = PROG_DEAD;
    end
    return r;
  endfunction

  function automatic tok_flags_t begin_plain(logic [7:0] c);
    tok_flags_t r;
    r             = FLAGS_RESET;
    r.first_upper = is_upper(c);
    return add_char(r, c);
  endfunction

  function automatic token_type_e classify(tok_flags_t f);
    token_type_e t;
    if (f.all_digits) begin
      t = TT_INTEGER;
    end else if (!f.decimal_broken) begin
      t = TT_DECIMAL;
    end else if ((f.true_prog == TRUE_LEN) || (f.false_prog == FALSE_LEN)) begin
      t = TT_BOOLEAN;
    end else if (f.first_upper) begin
      t = TT_REFERENCE;
    end else begin
      t = TT_SIMPLE;
    end
    return t;
  endfunction

endpackage

FILE: sv/ltlc_lexer.sv
// Lexer state and single-pass token classification, one character per transfer.
// Depends on ltlc_pkg for the mode, flag and token types.
module ltlc_lexer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      ch_i,
  input  logic            line_end_i,
  output logic            res_valid_o,
  output ltlc_pkg::token_t res_o
);

  ltlc_pkg::lex_mode_e                  mode_q, mode_d, mode_step;
  logic [ltlc_pkg::COL_W-1:0]           col_q, col_d;
  logic [ltlc_pkg::IDX_W-1:0]           cnt_q, cnt_d;
  logic [ltlc_pkg::START_W-1:0]         start_q, start_d;
  ltlc_pkg::tok_flags_t                 flags_q, flags_d;

  logic                                 is_quote, is_space;
  logic                                 emit_mid, emit_tail, res_valid;
  logic [ltlc_pkg::START_W-1:0]         col_ext, col_inc, end_col, len_raw;
  logic [ltlc_pkg::START_CMP_W-1:0]     st_cmp;
  logic [ltlc_pkg::LEN_CMP_W-1:0]       len_cmp;

  assign is_quote = (ch_i == ltlc_pkg::CH_QUOTE);
  assign is_space = (ch_i == ltlc_pkg::CH_SPACE);

  // Next mode and emit decisions
  always_comb begin
    mode_step = mode_q;
    emit_mid  = 1'b0;
    case (mode_q)
      ltlc_pkg::MODE_IDLE: begin
        if (is_quote) begin
          mode_step = ltlc_pkg::MODE_STRING;
        end else if (!is_space) begin
          mode_step = ltlc_pkg::MODE_PLAIN;
        end
      end
      ltlc_pkg::MODE_PLAIN: begin
        if (is_space) begin
          mode_step = ltlc_pkg::MODE_IDLE;
          emit_mid  = 1'b1;
        end
      end
      ltlc_pkg::MODE_STRING: begin
        if (is_quote) begin
          mode_step = ltlc_pkg::MODE_IDLE;
          emit_mid  = 1'b1;
        end
      end
      default: mode_step = ltlc_pkg::MODE_IDLE;
    endcase
    // an open token closes at the line end
    emit_tail = line_end_i && !emit_mid && (mode_step != ltlc_pkg::MODE_IDLE);
    mode_d    = line_end_i ? ltlc_pkg::MODE_IDLE : mode_step;
  end

  // Datapath: token start, flags, counters and the result
  always_comb begin
    col_ext = ltlc_pkg::START_W'(col_q);
    col_inc = col_ext + ltlc_pkg::START_W'(1);

    start_d = start_q;
    flags_d = flags_q;
    if (mode_q == ltlc_pkg::MODE_IDLE) begin
      if (is_quote) begin
        start_d = col_inc;
      end else if (!is_space) begin
        start_d = col_ext;
        flags_d = ltlc_pkg::begin_plain(ch_i);
      end
    end else if ((mode_q == ltlc_pkg::MODE_PLAIN) && !is_space) begin
      flags_d = ltlc_pkg::add_char(flags_q, ch_i);
    end

    res_valid = emit_mid || emit_tail;
    end_col   = emit_tail ? col_inc : col_ext;
    len_raw   = (end_col >= start_d) ? end_col - start_d : '0;

    st_cmp  = ltlc_pkg::START_CMP_W'(start_d);
    len_cmp = ltlc_pkg::LEN_CMP_W'(len_raw);

    if (emit_mid ? (mode_q == ltlc_pkg::MODE_STRING)
                 : (mode_step == ltlc_pkg::MODE_STRING)) begin
      res_o.token_type = ltlc_pkg::TT_STRING;
    end else begin
      res_o.token_type = ltlc_pkg::classify(flags_d);
    end
    res_o.token_index = cnt_q;
    if (st_cmp > ltlc_pkg::START_CMP_W'(ltlc_pkg::START_OUT_MAX)) begin
      res_o.start_column = ltlc_pkg::START_OUT_W'(ltlc_pkg::START_OUT_MAX);
    end else begin
      res_o.start_column = st_cmp[ltlc_pkg::START_OUT_W-1:0];
    end
    if (len_cmp > ltlc_pkg::LEN_CMP_W'(ltlc_pkg::LEN_OUT_MAX)) begin
      res_o.token_length = ltlc_pkg::LEN_OUT_W'(ltlc_pkg::LEN_OUT_MAX);
    end else begin
      res_o.token_length = len_cmp[ltlc_pkg::LEN_OUT_W-1:0];
    end
    res_o.last_in_line = line_end_i;

    // hold the column at the last position of an overlong line
    if (line_end_i) begin
      col_d = '0;
    end else if (col_q < ltlc_pkg::COL_W'(ltlc_pkg::MAX_LINE - 1)) begin
      col_d = col_q + ltlc_pkg::COL_W'(1);
    end else begin
      col_d = col_q;
    end

    if (line_end_i) begin
      cnt_d = '0;
    end else if (res_valid && (cnt_q != ltlc_pkg::IDX_W'(ltlc_pkg::IDX_MAX))) begin
      cnt_d = cnt_q + ltlc_pkg::IDX_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign res_valid_o = accept_i && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ltlc_pkg::MODE_IDLE;
      col_q   <= '0;
      cnt_q   <= '0;
      start_q <= '0;
      flags_q <= ltlc_pkg::FLAGS_RESET;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      flags_q <= flags_d;
    end
  end

  a_line_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && line_end_i) |=> (mode_q == ltlc_pkg::MODE_IDLE))
    else $error("lexer not between tokens after a line end");

  a_line_end_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && line_end_i) |=> ((cnt_q == '0) && (col_q == '0)))
    else $error("column or token count not cleared after a line end");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= ltlc_pkg::COL_W'(ltlc_pkg::MAX_LINE - 1))
    else $error("column beyond the line limit");

endmodule

FILE: sv/ltlc_out_skid.sv
// Output register with one skid entry for token results.
// Depends on ltlc_pkg for the token_t payload.
module ltlc_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ltlc_pkg::token_t push_data_i,
  output logic             full_o,
  output logic             out_valid_o,
  output ltlc_pkg::token_t out_data_o,
  input  logic             out_stall_i
);

  logic             out_valid_q, skid_valid_q;
  ltlc_pkg::token_t out_data_q, skid_data_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= skid_valid_q && push_i;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload: refill the output from the skid entry first
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_data_q  <= skid_data_q;
        skid_data_q <= push_data_i;
      end else if (push_i) begin
        out_data_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_data_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while the output register is empty");

  a_push_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && out_stall_i) |=> (skid_valid_q && out_valid_q))
    else $error("result lost while the output was stalled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed into a full skid stage");

endmodule

FILE: sv/line_token_lexer_classifier_top.sv
// Top level of the line token lexer and classifier.
// Depends on ltlc_pkg, ltlc_lexer and ltlc_out_skid.
//
// Input channel: one character per transfer on ch_i, with line_end_i high on
// the last character of a line (in_valid_i / in_stall_o).
// Output channel: one result per closed token: type, index within the line,
// start column, length and a flag for a token closed at the line end
// (out_valid_o / out_stall_i).
// Throughput: one character per cycle while in_stall_o is low. The lexer state
// updates in the cycle of the transfer, so a character can follow in every
// cycle that is not stalled. The result of the character that closes a token is
// registered in the output register, or in the skid entry behind a stalled result.
// The output register has one skid entry behind it; in_stall_o rises only
// once that entry holds a result, so characters keep flowing while one
// result waits to be taken, and the input stalls on the next.
// Reset clears the lexer to column zero, token index zero, between tokens,
// and empties the output register and skid entry.
module line_token_lexer_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        line_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_type_o,
  output logic [10:0] token_index_o,
  output logic [11:0] start_column_o,
  output logic [12:0] token_length_o,
  output logic        last_in_line_o
);

  logic             accept;
  logic             res_valid;
  logic             skid_full;
  ltlc_pkg::token_t res, out_data;

  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  ltlc_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ch_i        (ch_i),
    .line_end_i  (line_end_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ltlc_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .out_stall_i (out_stall_i)
  );

  assign token_type_o   = 3'(out_data.token_type);
  assign token_index_o  = out_data.token_index;
  assign start_column_o = out_data.start_column;
  assign token_length_o = out_data.token_length;
  assign last_in_line_o = out_data.last_in_line;

endmodule

FILE: sim/tb_line_token_lexer_classifier_top.sv
// Testbench for line_token_lexer_classifier_top: random and directed text lines,
// with results checked against an in-bench model of the lexer.
// Depends on ltlc_pkg and the lexer RTL only.
`timescale 1ns / 1ps

module tb_line_token_lexer_classifier_top;

  localparam int unsigned WORD_DEAD = 7;
  localparam int unsigned LAST_COL  = ltlc_pkg::MAX_LINE - 1;

  // Tracks the lexer state and holds the tokens it should produce, oldest first.
  class token_scoreboard;
    int unsigned         column;
    int unsigned         tok_count;
    int unsigned         start_col;
    ltlc_pkg::lex_mode_e mode;
    bit                  digits_only;
    bit                  has_dot;
    bit                  not_decimal;
    bit                  upper_first;
    int unsigned         true_hits;
    int unsigned         false_hits;
    ltlc_pkg::token_t    pending[$];
    int unsigned         mismatches;
    int unsigned         tokens_checked;

    function new();
      column         = 0;
      tok_count      = 0;
      start_col      = 0;
      mode           = ltlc_pkg::MODE_IDLE;
      digits_only    = 1'b1;
      has_dot        = 1'b0;
      not_decimal    = 1'b0;
      upper_first    = 1'b0;
      true_hits      = 0;
      false_hits     = 0;
      mismatches     = 0;
      tokens_checked = 0;
    endfunction

    function int unsigned word_step(int unsigned hits, string word, logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= ltlc_pkg::CH_UPPER_A && c <= ltlc_pkg::CH_UPPER_Z) ? c + 8'd32 : c;
      if (hits < word.len() && lc == word[hits]) return hits + 1;
      return WORD_DEAD;
    endfunction

    function void take_char(logic [7:0] c);
      if (!(c >= ltlc_pkg::CH_ZERO && c <= ltlc_pkg::CH_NINE)) begin
        digits_only = 1'b0;
        if (c == ltlc_pkg::CH_DOT) begin
          if (has_dot) not_decimal = 1'b1;
          has_dot = 1'b1;
        end else begin
          not_decimal = 1'b1;
        end
      end
      true_hits  = word_step(true_hits, "true", c);
      false_hits = word_step(false_hits, "false", c);
    endfunction

    function void open_plain(logic [7:0] c);
      digits_only = 1'b1;
      has_dot     = 1'b0;
      not_decimal = 1'b0;
      upper_first = (c >= ltlc_pkg::CH_UPPER_A && c <= ltlc_pkg::CH_UPPER_Z);
      true_hits   = 0;
      false_hits  = 0;
      take_char(c);
    endfunction

    function ltlc_pkg::token_type_e plain_kind();
      if (digits_only) return ltlc_pkg::TT_INTEGER;
      if (!not_decimal) return ltlc_pkg::TT_DECIMAL;
      if (true_hits == 4 || false_hits == 5) return ltlc_pkg::TT_BOOLEAN;
      if (upper_first) return ltlc_pkg::TT_REFERENCE;
      return ltlc_pkg::TT_SIMPLE;
    endfunction

    function void add_token(ltlc_pkg::token_type_e kind, int unsigned end_col, bit last);
      ltlc_pkg::token_t t;
      int unsigned      len;
      len = (end_col >= start_col) ? end_col - start_col : 0;
      if (len > ltlc_pkg::LEN_OUT_MAX) len = ltlc_pkg::LEN_OUT_MAX;
      t.token_type   = kind;
      t.token_index  = 11'(tok_count);
      t.start_column = (start_col > ltlc_pkg::START_OUT_MAX) ?
                       12'(ltlc_pkg::START_OUT_MAX) : 12'(start_col);
      t.token_length = 13'(len);
      t.last_in_line = last;
      pending.insert(pending.size(), t);
      if (tok_count < ltlc_pkg::IDX_MAX) tok_count++;
    endfunction

    function void note_char(logic [7:0] c, logic le);
      int unsigned col;
      bit          closed;
      col    = column;
      closed = 1'b0;
      case (mode)
        ltlc_pkg::MODE_IDLE: begin
          if (c == ltlc_pkg::CH_QUOTE) begin
            mode      = ltlc_pkg::MODE_STRING;
            start_col = col + 1;
          end else if (c != ltlc_pkg::CH_SPACE) begin
            mode      = ltlc_pkg::MODE_PLAIN;
            start_col = col;
            open_plain(c);
          end
        end
        ltlc_pkg::MODE_PLAIN: begin
          if (c == ltlc_pkg::CH_SPACE) begin
            add_token(plain_kind(), col, le);
            closed = 1'b1;
            mode   = ltlc_pkg::MODE_IDLE;
          end else begin
            take_char(c);
          end
        end
        default: begin
          if (c == ltlc_pkg::CH_QUOTE) begin
            add_token(ltlc_pkg::TT_STRING, col, le);
            closed = 1'b1;
            mode   = ltlc_pkg::MODE_IDLE;
          end
        end
      endcase
      if (le) begin
        // close whatever is still open at the line end
        if (!closed && mode == ltlc_pkg::MODE_PLAIN)
          add_token(plain_kind(), col + 1, 1'b1);
        else if (!closed && mode == ltlc_pkg::MODE_STRING)
          add_token(ltlc_pkg::TT_STRING, col + 1, 1'b1);
        mode      = ltlc_pkg::MODE_IDLE;
        column    = 0;
        tok_count = 0;
      end else if (col < LAST_COL) begin
        column = col + 1;
      end
    endfunction

    function void check_token(logic [2:0] kind, logic [10:0] idx, logic [11:0] st,
                              logic [12:0] len, logic last);
      ltlc_pkg::token_t t;
      tokens_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: token with none expected: type %0d index %0d start %0d len %0d last %0d",
                   $realtime, kind, idx, st, len, last);
        return;
      end
      t = pending.pop_front();
      if (kind !== t.token_type || idx !== t.token_index || st !== t.start_column ||
          len !== t.token_length || last !== t.last_in_line) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: token mismatch: exp type %0d index %0d start %0d len %0d last %0d,",
                   $realtime, t.token_type, t.token_index, t.start_column, t.token_length,
                   t.last_in_line,
                   " got type %0d index %0d start %0d len %0d last %0d",
                   kind, idx, st, len, last);
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i           = 8'h00;
  logic        line_end_i     = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  token_type_o;
  logic [10:0] token_index_o;
  logic [11:0] start_column_o;
  logic [12:0] token_length_o;
  logic        last_in_line_o;

  token_scoreboard sb = new();
  bit              idle_on;
  int unsigned     chars_sent;
  int unsigned     lines_sent;
  logic [7:0]      line_buf[$];

  line_token_lexer_classifier_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_type_o   (token_type_o),
    .token_index_o  (token_index_o),
    .start_column_o (start_column_o),
    .token_length_o (token_length_o),
    .last_in_line_o (last_in_line_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_char(logic [7:0] c, logic le);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    line_end_i <= le;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_char(c, le);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
  endtask

  task automatic send_text(string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.insert(line_buf.size(), s[i]);
    send_line();
  endtask

  // Build one line of mostly well-formed tokens, with some noise bytes mixed in.
  task automatic fill_random_line();
    logic [7:0] tok[$];
    logic [7:0] c;
    string      word;
    int         len;
    bit         glue;
    line_buf.delete();
    repeat ($urandom_range(1, 6)) begin
      tok.delete();
      glue = 1'b0;
      len  = $urandom_range(1, 5);
      case ($urandom_range(0, 6))
        0: repeat (len)
             tok.insert(tok.size(),
                        8'($urandom_range(ltlc_pkg::CH_ZERO, ltlc_pkg::CH_NINE)));
        1: begin
          repeat (len)
            tok.insert(tok.size(),
                       8'($urandom_range(ltlc_pkg::CH_ZERO, ltlc_pkg::CH_NINE)));
          tok.insert($urandom_range(0, tok.size()), ltlc_pkg::CH_DOT);
          if ($urandom_range(0, 3) == 0)
            tok.insert($urandom_range(0, tok.size()), ltlc_pkg::CH_DOT);
        end
        2: begin
          tok.insert(tok.size(), ltlc_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(32, 126));
            tok.insert(tok.size(), c == ltlc_pkg::CH_QUOTE ? ltlc_pkg::CH_SPACE : c);
          end
          // leave a few unterminated so they run to the line end
          if ($urandom_range(0, 5) != 0) tok.insert(tok.size(), ltlc_pkg::CH_QUOTE);
          glue = ($urandom_range(0, 2) == 0);
        end
        3: begin
          word = $urandom_range(0, 1) ? "true" : "false";
          for (int i = 0; i < word.len(); i++) begin
            c = word[i];
            tok.insert(tok.size(), $urandom_range(0, 1) ? c - 8'd32 : c);
          end
          case ($urandom_range(0, 5))
            0: void'(tok.pop_back());
            1: tok.insert(tok.size(), 8'($urandom_range(97, 122)));
            default: ;
          endcase
        end
        4: begin
          tok.insert(tok.size(),
                     8'($urandom_range(ltlc_pkg::CH_UPPER_A, ltlc_pkg::CH_UPPER_Z)));
          repeat (len - 1) tok.insert(tok.size(), 8'($urandom_range(97, 122)));
        end
        5: begin
          repeat (len) tok.insert(tok.size(), 8'($urandom_range(97, 122)));
          if ($urandom_range(0, 3) == 0)
            tok.insert($urandom_range(1, tok.size()), ltlc_pkg::CH_QUOTE);
        end
        default: repeat (len) tok.insert(tok.size(), 8'($urandom_range(0, 255)));
      endcase
      foreach (tok[i]) line_buf.insert(line_buf.size(), tok[i]);
      if (!glue)
        repeat ($urandom_range(1, 2)) line_buf.insert(line_buf.size(), ltlc_pkg::CH_SPACE);
    end
    // keep trailing spaces on some lines only
    if ($urandom_range(0, 4) != 0)
      while (line_buf.size() > 1 && line_buf[$] == ltlc_pkg::CH_SPACE)
        void'(line_buf.pop_back());
  endtask

  task automatic send_random(int unsigned count);
    int unsigned stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      fill_random_line();
      send_line();
    end
  endtask

  // Result side: check each transfer, stall in random bursts and once for a long stretch.
  initial begin : receiver
    int unsigned burst;
    bit          held_long;
    burst     = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        sb.check_token(token_type_o, token_index_o, start_column_o, token_length_o,
                       last_in_line_o);
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall_i <= 1'b0;
      end else if (!held_long && sb.tokens_checked >= 40) begin
        held_long = 1'b1;
        out_stall_i <= 1'b1;
        burst = 300;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        burst = $urandom_range(1, 14);
      end
    end
  end

  initial begin : stimulus
    idle_on    = 1'b1;
    chars_sent = 0;
    lines_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every token class, a string glued to the next token, a quote inside a
    // plain token and trailing spaces
    send_text("7 1.5 \"a b\"Ab tRUE x\"y ");
    send_text("\"q");
    send_text("\"");
    line_buf = '{8'h00, 8'h09, 8'hFF};
    send_line();

    send_random(140);
    idle_on = 1'b0;
    send_random(60);
    idle_on = 1'b1;
    send_random(140);

    // no idling on either side from here on
    idle_on = 1'b0;
    send_random(50);
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d characters over %0d lines, %0d tokens compared,",
             chars_sent, lines_sent, sb.tokens_checked);
    $display("with glued and unterminated strings, mixed-case booleans, a long output hold; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_line_token_lexer_classifier_top: clean");
    end else begin
      $display("tb_line_token_lexer_classifier_top: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d tokens still awaited.", sb.pending.size());
    $display("tb_line_token_lexer_classifier_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ltlc_pkg.sv
sv/ltlc_lexer.sv
sv/ltlc_out_skid.sv
sv/line_token_lexer_classifier_top.sv
sim/tb_line_token_lexer_classifier_top.sv
